// ===== rtl/core/spcp_pkg.sv =====
// Shared types and constants for the sprite camera projection unit.
package spcp_pkg;

   // Screen defaults
   localparam int SCREEN_WIDTH_DEF  = 640;
   localparam int SCREEN_HEIGHT_DEF = 480;

   // Field widths
   localparam int POS_W   = 24;
   localparam int VEC_W   = 16;
   localparam int Q16_W   = 32;
   localparam int COL_W   = 16;
   localparam int HGT_W   = 15;
   localparam int ROW_W   = 12;
   localparam int CSR_IDX_W = 3;

   // Quotient widths of the two divider banks
   localparam int XF_QUO_W  = 32;
   localparam int SCR_QUO_W = 16;

   // One in Q16.16
   localparam logic signed [Q16_W-1:0] Q16_ONE = 32'sh0001_0000;

   // Register reset values
   localparam logic [POS_W-1:0]        PLAYER_POS_X_RST = '0;
   localparam logic [POS_W-1:0]        PLAYER_POS_Y_RST = '0;
   localparam logic signed [VEC_W-1:0] VIEW_DIR_X_RST   = -16'sd16384;
   localparam logic signed [VEC_W-1:0] VIEW_DIR_Y_RST   = 16'sd0;
   localparam logic signed [VEC_W-1:0] CAM_PLANE_X_RST  = 16'sd0;
   localparam logic signed [VEC_W-1:0] CAM_PLANE_Y_RST  = 16'sd10813;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLAYER_POS_X = 3'd0,
      CSR_PLAYER_POS_Y = 3'd1,
      CSR_VIEW_DIR_X   = 3'd2,
      CSR_VIEW_DIR_Y   = 3'd3,
      CSR_CAM_PLANE_X  = 3'd4,
      CSR_CAM_PLANE_Y  = 3'd5
   } csr_idx_type;

   // Sideband of the view transform dividers
   typedef struct packed {
      logic sign;
      logic huge;
      logic degen;
   } xf_side_type;

   // Sideband of the screen column divider
   typedef struct packed {
      logic signed [Q16_W-1:0] view_x;
      logic signed [Q16_W-1:0] depth;
      logic                    sign;
      logic                    huge;
      logic                    degen;
   } col_side_type;

endpackage

// ===== rtl/core/spcp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, global stall.
module spcp_div #(
   parameter int NUM_W  = 56,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [QUO_W-1:0]  vld_ff, vld_in;
   logic [NUM_W-1:0]  rem_ff  [QUO_W];
   logic [NUM_W-1:0]  rem_in  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_in  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [DEN_W-1:0]  den_in  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];
   logic [SIDE_W-1:0] side_in [QUO_W];

   // One trial subtraction per stage, most significant quotient bit first
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [NUM_W-1:0]  rem_src;
      logic [QUO_W-1:0]  quo_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic              vld_src;
      logic [CMP_W-1:0]  rem_ext;
      logic [CMP_W-1:0]  trial;
      logic              take;

      if (k == 0) begin : g_first
         assign rem_src  = in_num;
         assign quo_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      assign rem_ext    = CMP_W'(rem_src);
      assign trial      = CMP_W'(den_src) << (QUO_W - 1 - k);
      assign take       = rem_ext >= trial;
      assign rem_in[k]  = take ? NUM_W'(rem_ext - trial) : rem_src;
      assign quo_in[k]  = {quo_src[QUO_W-2:0], take};
      assign den_in[k]  = den_src;
      assign side_in[k] = side_src;
      assign vld_in[k]  = vld_src;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ===== rtl/core/sprite_camera_projection_unit.sv =====
// Top level of the sprite camera projection unit: transform, divide, bounds.
//
// Projects one sprite map position per cycle into the camera set by the
// configuration registers and returns view x, depth, screen column, height and
// clamped column and row bounds. From an input transfer to the result on the
// rsp_ port, the pipeline holds four stages of relative position, determinant
// and cross products, a 32-stage divider bank for view x and depth, four stages
// for the column numerator, a 16-stage divider bank for column and height, and
// the output register. One item enters every cycle; a stalled result holds the
// whole pipeline, which then refuses new input.
// Registers are written at index 0..5 through csr_, always ready; write them
// only while no item is in flight.
module sprite_camera_projection_unit
   import spcp_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [POS_W-1:0]         req_sprite_pos_x,
   input  logic [POS_W-1:0]         req_sprite_pos_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [Q16_W-1:0]  rsp_view_x,
   output logic signed [Q16_W-1:0]  rsp_depth,
   output logic signed [COL_W-1:0]  rsp_screen_column,
   output logic [HGT_W-1:0]         rsp_sprite_height,
   output logic [HGT_W-1:0]         rsp_start_col,
   output logic signed [COL_W-1:0]  rsp_end_col,
   output logic [ROW_W-1:0]         rsp_start_row,
   output logic [ROW_W-1:0]         rsp_end_row,
   output logic                     rsp_degenerate,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [POS_W-1:0]         csr_data
);

   localparam int HALF_W   = SCREEN_WIDTH / 2;
   localparam int HALF_H   = SCREEN_HEIGHT / 2;
   localparam int HW_W     = $clog2(HALF_W + 1) + 1;
   localparam int CPROD_W  = HW_W + Q16_W + 1;
   localparam int CCMP_W   = (CPROD_W > Q16_W + SCR_QUO_W) ? CPROD_W : Q16_W + SCR_QUO_W;
   localparam int HNUM_W   = $clog2(SCREEN_HEIGHT + 1) + 16;
   localparam int REL_W    = POS_W + 1;
   localparam int PROD_W   = VEC_W + REL_W;
   localparam int CROSS_W  = PROD_W + 1;
   localparam int XNUM_W   = CROSS_W + 14;
   localparam int DET_W    = 2 * VEC_W + 1;
   localparam int B_W      = 18;
   localparam logic signed [HW_W-1:0] HALF_W_S = HW_W'(HALF_W);
   localparam logic [HNUM_W-1:0]      HNUM     = HNUM_W'(SCREEN_HEIGHT) << 16;
   localparam logic signed [B_W-1:0]  SW_S     = B_W'(SCREEN_WIDTH);
   localparam logic signed [B_W-1:0]  SH_S     = B_W'(SCREEN_HEIGHT);
   localparam logic signed [B_W-1:0]  HALF_H_S = B_W'(HALF_H);

   // Configuration registers
   logic [POS_W-1:0]        player_pos_x_ff, player_pos_y_ff;
   logic signed [VEC_W-1:0] view_dir_x_ff, view_dir_y_ff;
   logic signed [VEC_W-1:0] cam_plane_x_ff, cam_plane_y_ff;

   logic en;

   assign csr_ready = 1'b1;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         player_pos_x_ff <= PLAYER_POS_X_RST;
         player_pos_y_ff <= PLAYER_POS_Y_RST;
         view_dir_x_ff   <= VIEW_DIR_X_RST;
         view_dir_y_ff   <= VIEW_DIR_Y_RST;
         cam_plane_x_ff  <= CAM_PLANE_X_RST;
         cam_plane_y_ff  <= CAM_PLANE_Y_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_PLAYER_POS_X: player_pos_x_ff <= csr_data;
            CSR_PLAYER_POS_Y: player_pos_y_ff <= csr_data;
            CSR_VIEW_DIR_X:   view_dir_x_ff   <= csr_data[VEC_W-1:0];
            CSR_VIEW_DIR_Y:   view_dir_y_ff   <= csr_data[VEC_W-1:0];
            CSR_CAM_PLANE_X:  cam_plane_x_ff  <= csr_data[VEC_W-1:0];
            CSR_CAM_PLANE_Y:  cam_plane_y_ff  <= csr_data[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: move when the output register is free or being drained
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // ---------------- Stage 1: relative position, determinant products
   logic                     v1_ff, v1_in;
   logic signed [REL_W-1:0]  rel_x1_ff, rel_x1_in, rel_y1_ff, rel_y1_in;
   logic signed [2*VEC_W-1:0] pa1_ff, pa1_in, pb1_ff, pb1_in;

   assign v1_in     = req_valid;
   assign rel_x1_in = $signed({1'b0, req_sprite_pos_x}) - $signed({1'b0, player_pos_x_ff});
   assign rel_y1_in = $signed({1'b0, req_sprite_pos_y}) - $signed({1'b0, player_pos_y_ff});
   assign pa1_in    = cam_plane_x_ff * view_dir_y_ff;
   assign pb1_in    = view_dir_x_ff * cam_plane_y_ff;

   // ---------------- Stage 2: determinant, cross products
   logic                      v2_ff, v2_in;
   logic signed [DET_W-1:0]   det2_ff, det2_in;
   logic signed [PROD_W-1:0]  mxa2_ff, mxa2_in, mxb2_ff, mxb2_in;
   logic signed [PROD_W-1:0]  mya2_ff, mya2_in, myb2_ff, myb2_in;

   assign v2_in   = v1_ff;
   assign det2_in = DET_W'(pa1_ff) - DET_W'(pb1_ff);
   assign mxa2_in = view_dir_y_ff * rel_x1_ff;
   assign mxb2_in = view_dir_x_ff * rel_y1_ff;
   assign mya2_in = cam_plane_x_ff * rel_y1_ff;
   assign myb2_in = cam_plane_y_ff * rel_x1_ff;

   // ---------------- Stage 3: numerators
   logic                      v3_ff, v3_in;
   logic signed [DET_W-1:0]   det3_ff, det3_in;
   logic signed [CROSS_W-1:0] nx3_ff, nx3_in, ny3_ff, ny3_in;

   assign v3_in   = v2_ff;
   assign det3_in = det2_ff;
   assign nx3_in  = CROSS_W'(mxa2_ff) - CROSS_W'(mxb2_ff);
   assign ny3_in  = CROSS_W'(mya2_ff) - CROSS_W'(myb2_ff);

   // ---------------- Stage 4: magnitudes, signs, overflow precheck
   logic                    v4_ff, v4_in;
   logic [XNUM_W-1:0]       nxm4_ff, nxm4_in, nym4_ff, nym4_in;
   logic [Q16_W-1:0]        dm4_ff, dm4_in;
   xf_side_type             xs4_ff, xs4_in, ys4_ff, ys4_in;
   logic [CROSS_W-1:0]      ax3, ay3;
   logic [DET_W-1:0]        ad3;
   logic [XNUM_W+8-1:0]     ext_x3, ext_y3, ext_d3;

   always_comb begin
      ax3     = nx3_ff[CROSS_W-1] ? CROSS_W'(-nx3_ff) : CROSS_W'(nx3_ff);
      ay3     = ny3_ff[CROSS_W-1] ? CROSS_W'(-ny3_ff) : CROSS_W'(ny3_ff);
      ad3     = det3_ff[DET_W-1] ? DET_W'(-det3_ff) : DET_W'(det3_ff);
      v4_in   = v3_ff;
      nxm4_in = {ax3, 14'b0};
      nym4_in = {ay3, 14'b0};
      dm4_in  = ad3[Q16_W-1:0];
      ext_x3  = (XNUM_W+8)'(nxm4_in);
      ext_y3  = (XNUM_W+8)'(nym4_in);
      ext_d3  = {dm4_in, {XF_QUO_W{1'b0}}};
      xs4_in.sign  = nx3_ff[CROSS_W-1] ^ det3_ff[DET_W-1];
      xs4_in.huge  = ext_x3 >= ext_d3;
      xs4_in.degen = det3_ff == '0;
      ys4_in.sign  = ny3_ff[CROSS_W-1] ^ det3_ff[DET_W-1];
      ys4_in.huge  = ext_y3 >= ext_d3;
      ys4_in.degen = det3_ff == '0;
   end

   // ---------------- View transform dividers
   logic                 xq_valid, yq_valid;
   logic [XF_QUO_W-1:0]  xq, yq;
   logic [$bits(xf_side_type)-1:0] xq_side, yq_side;
   xf_side_type          xs_o, ys_o;

   spcp_div #(
      .NUM_W(XNUM_W), .DEN_W(Q16_W), .QUO_W(XF_QUO_W), .SIDE_W($bits(xf_side_type))
   ) u_div_x (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4_ff), .in_num(nxm4_ff), .in_den(dm4_ff), .in_side(xs4_ff),
      .out_valid(xq_valid), .out_quo(xq), .out_side(xq_side)
   );

   spcp_div #(
      .NUM_W(XNUM_W), .DEN_W(Q16_W), .QUO_W(XF_QUO_W), .SIDE_W($bits(xf_side_type))
   ) u_div_y (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v4_ff), .in_num(nym4_ff), .in_den(dm4_ff), .in_side(ys4_ff),
      .out_valid(yq_valid), .out_quo(yq), .out_side(yq_side)
   );

   assign xs_o = xf_side_type'(xq_side);
   assign ys_o = xf_side_type'(yq_side);

   // ---------------- Stage 5: sign, saturate, zero depth, degenerate camera
   logic                    v5_ff, v5_in, dg5_ff, dg5_in;
   logic signed [Q16_W-1:0] vx5_ff, vx5_in, dp5_ff, dp5_in;
   logic signed [Q16_W-1:0] vx_sat, dp_sat;

   always_comb begin
      if (!xs_o.sign) begin
         vx_sat = (xs_o.huge || xq[Q16_W-1]) ? 32'sh7FFF_FFFF : $signed(xq);
      end else begin
         vx_sat = (xs_o.huge || xq > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-xq);
      end
      if (!ys_o.sign) begin
         dp_sat = (ys_o.huge || yq[Q16_W-1]) ? 32'sh7FFF_FFFF : $signed(yq);
      end else begin
         dp_sat = (ys_o.huge || yq > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-yq);
      end
      if (dp_sat == '0) begin
         dp_sat = Q16_ONE;
      end
      v5_in  = xq_valid;
      dg5_in = xs_o.degen;
      vx5_in = xs_o.degen ? '0 : vx_sat;
      dp5_in = xs_o.degen ? Q16_ONE : dp_sat;
   end

   // ---------------- Stage 6: column sum, depth magnitude
   logic                     v6_ff, v6_in, dg6_ff, dg6_in, sd6_ff, sd6_in;
   logic signed [Q16_W-1:0]  vx6_ff, vx6_in, dp6_ff, dp6_in;
   logic signed [Q16_W:0]    sum6_ff, sum6_in;
   logic [Q16_W-1:0]         dm6_ff, dm6_in;

   assign v6_in   = v5_ff;
   assign dg6_in  = dg5_ff;
   assign vx6_in  = vx5_ff;
   assign dp6_in  = dp5_ff;
   assign sd6_in  = dp5_ff[Q16_W-1];
   assign sum6_in = (Q16_W+1)'(dp5_ff) + (Q16_W+1)'(vx5_ff);
   assign dm6_in  = dp5_ff[Q16_W-1] ? Q16_W'(-dp5_ff) : Q16_W'(dp5_ff);

   // ---------------- Stage 7: column numerator product
   logic                      v7_ff, v7_in, dg7_ff, dg7_in, sd7_ff, sd7_in;
   logic signed [Q16_W-1:0]   vx7_ff, vx7_in, dp7_ff, dp7_in;
   logic signed [CPROD_W-1:0] cp7_ff, cp7_in;
   logic [Q16_W-1:0]          dm7_ff, dm7_in;

   assign v7_in  = v6_ff;
   assign dg7_in = dg6_ff;
   assign vx7_in = vx6_ff;
   assign dp7_in = dp6_ff;
   assign sd7_in = sd6_ff;
   assign dm7_in = dm6_ff;
   assign cp7_in = HALF_W_S * sum6_ff;

   // ---------------- Stage 8: column magnitude, sign, overflow prechecks
   logic                  v8_ff, v8_in, hh8_ff, hh8_in;
   logic [CPROD_W-1:0]    cm8_ff, cm8_in;
   logic [Q16_W-1:0]      dm8_ff, dm8_in;
   col_side_type          cs8_ff, cs8_in;
   logic [CCMP_W-1:0]     ext_c7, ext_dc7;

   always_comb begin
      v8_in   = v7_ff;
      cm8_in  = cp7_ff[CPROD_W-1] ? CPROD_W'(-cp7_ff) : CPROD_W'(cp7_ff);
      dm8_in  = dm7_ff;
      ext_c7  = CCMP_W'(cm8_in);
      ext_dc7 = CCMP_W'({dm7_ff, {SCR_QUO_W{1'b0}}});
      hh8_in  = dm7_ff <= Q16_W'(SCREEN_HEIGHT);
      cs8_in.view_x = vx7_ff;
      cs8_in.depth  = dp7_ff;
      cs8_in.sign   = cp7_ff[CPROD_W-1] ^ sd7_ff;
      cs8_in.huge   = ext_c7 >= ext_dc7;
      cs8_in.degen  = dg7_ff;
   end

   // ---------------- Screen column and height dividers
   logic                  cq_valid, hq_valid;
   logic [SCR_QUO_W-1:0]  cq, hq;
   logic [$bits(col_side_type)-1:0] cq_side;
   logic                  hq_huge;
   col_side_type          cs_o;

   spcp_div #(
      .NUM_W(CPROD_W), .DEN_W(Q16_W), .QUO_W(SCR_QUO_W), .SIDE_W($bits(col_side_type))
   ) u_div_col (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v8_ff), .in_num(cm8_ff), .in_den(dm8_ff), .in_side(cs8_ff),
      .out_valid(cq_valid), .out_quo(cq), .out_side(cq_side)
   );

   spcp_div #(
      .NUM_W(HNUM_W), .DEN_W(Q16_W), .QUO_W(SCR_QUO_W), .SIDE_W(1)
   ) u_div_hgt (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(v8_ff), .in_num(HNUM), .in_den(dm8_ff), .in_side(hh8_ff),
      .out_valid(hq_valid), .out_quo(hq), .out_side(hq_huge)
   );

   assign cs_o = col_side_type'(cq_side);

   // ---------------- Stage 9: saturate column and height, clamp bounds
   logic                     v9_ff, v9_in;
   logic signed [Q16_W-1:0]  vx9_ff, vx9_in, dp9_ff, dp9_in;
   logic signed [COL_W-1:0]  col9_ff, col9_in, ecol9_ff, ecol9_in;
   logic [HGT_W-1:0]         hgt9_ff, hgt9_in, scol9_ff, scol9_in;
   logic [ROW_W-1:0]         srow9_ff, srow9_in, erow9_ff, erow9_in;
   logic                     dg9_ff, dg9_in;
   logic [HGT_W-2:0]         half;
   logic signed [B_W-1:0]    half_s, col_w, scol_w, ecol_w, srow_w, erow_w;

   always_comb begin
      if (!cs_o.sign) begin
         col9_in = (cs_o.huge || cq[SCR_QUO_W-1]) ? 16'sh7FFF : $signed(cq);
      end else begin
         col9_in = (cs_o.huge || cq > 16'h8000) ? 16'sh8000 : $signed(-cq);
      end
      hgt9_in = (hq_huge || hq[SCR_QUO_W-1]) ? {HGT_W{1'b1}} : hq[HGT_W-1:0];
      half    = hgt9_in[HGT_W-1:1];
      half_s  = $signed(B_W'(half));
      col_w   = B_W'(col9_in);
      scol_w  = col_w - half_s;
      ecol_w  = col_w + half_s;
      srow_w  = HALF_H_S - half_s;
      erow_w  = HALF_H_S + half_s;
      scol9_in = (scol_w < 0) ? '0 : scol_w[HGT_W-1:0];
      ecol9_in = (ecol_w >= SW_S) ? COL_W'(SW_S - 1) : ecol_w[COL_W-1:0];
      srow9_in = (srow_w < 0) ? '0 : srow_w[ROW_W-1:0];
      erow9_in = (erow_w >= SH_S) ? ROW_W'(SH_S - 1) : erow_w[ROW_W-1:0];
      v9_in   = cq_valid;
      vx9_in  = cs_o.view_x;
      dp9_in  = cs_o.depth;
      dg9_in  = cs_o.degen;
   end

   // Advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
         v6_ff <= v6_in;
         v7_ff <= v7_in;
         v8_ff <= v8_in;
         v9_ff <= v9_in;
      end
   end

   // Advance stage payload
   always_ff @(posedge clock) begin
      if (en) begin
         rel_x1_ff <= rel_x1_in;
         rel_y1_ff <= rel_y1_in;
         pa1_ff    <= pa1_in;
         pb1_ff    <= pb1_in;
         det2_ff   <= det2_in;
         mxa2_ff   <= mxa2_in;
         mxb2_ff   <= mxb2_in;
         mya2_ff   <= mya2_in;
         myb2_ff   <= myb2_in;
         det3_ff   <= det3_in;
         nx3_ff    <= nx3_in;
         ny3_ff    <= ny3_in;
         nxm4_ff   <= nxm4_in;
         nym4_ff   <= nym4_in;
         dm4_ff    <= dm4_in;
         xs4_ff    <= xs4_in;
         ys4_ff    <= ys4_in;
         dg5_ff    <= dg5_in;
         vx5_ff    <= vx5_in;
         dp5_ff    <= dp5_in;
         dg6_ff    <= dg6_in;
         sd6_ff    <= sd6_in;
         vx6_ff    <= vx6_in;
         dp6_ff    <= dp6_in;
         sum6_ff   <= sum6_in;
         dm6_ff    <= dm6_in;
         dg7_ff    <= dg7_in;
         sd7_ff    <= sd7_in;
         vx7_ff    <= vx7_in;
         dp7_ff    <= dp7_in;
         cp7_ff    <= cp7_in;
         dm7_ff    <= dm7_in;
         hh8_ff    <= hh8_in;
         cm8_ff    <= cm8_in;
         dm8_ff    <= dm8_in;
         cs8_ff    <= cs8_in;
         vx9_ff    <= vx9_in;
         dp9_ff    <= dp9_in;
         col9_ff   <= col9_in;
         ecol9_ff  <= ecol9_in;
         hgt9_ff   <= hgt9_in;
         scol9_ff  <= scol9_in;
         srow9_ff  <= srow9_in;
         erow9_ff  <= erow9_in;
         dg9_ff    <= dg9_in;
      end
   end

   // Drive the result channel from the last stage
   assign rsp_valid         = v9_ff;
   assign rsp_view_x        = vx9_ff;
   assign rsp_depth         = dp9_ff;
   assign rsp_screen_column = col9_ff;
   assign rsp_sprite_height = hgt9_ff;
   assign rsp_start_col     = scol9_ff;
   assign rsp_end_col       = ecol9_ff;
   assign rsp_start_row     = srow9_ff;
   assign rsp_end_row       = erow9_ff;
   assign rsp_degenerate    = dg9_ff;

   // Parallel divider banks must stay in lockstep
   assert property (@(posedge clock) disable iff (reset) xq_valid == yq_valid)
      else $error("view x and depth dividers out of step");

   assert property (@(posedge clock) disable iff (reset) cq_valid == hq_valid)
      else $error("column and height dividers out of step");

   // A degenerate camera reports the fixed view position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_view_x == '0 && rsp_depth == Q16_ONE)
      else $error("degenerate result with wrong view position");

   // Depth is never zero
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> rsp_depth != '0)
      else $error("zero depth on result");

endmodule

// ===== dv/sprite_camera_projection_unit_test.sv =====
// Self-checking testbench for the sprite camera projection unit.
module sprite_camera_projection_unit_test;
   import spcp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Indexes past the register file; writes there must leave every register alone
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;
   localparam int DRAIN_CYCLES   = 64;
   localparam int BACKLOG_CYCLES = 300;
   localparam int STALL_LIMIT    = 20000;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
   } sprite_type;

   typedef struct packed {
      logic signed [Q16_W-1:0] view_x;
      logic signed [Q16_W-1:0] depth;
      logic signed [COL_W-1:0] column;
      logic [HGT_W-1:0]        height;
      logic [HGT_W-1:0]        start_col;
      logic signed [COL_W-1:0] end_col;
      logic [ROW_W-1:0]        start_row;
      logic [ROW_W-1:0]        end_row;
      logic                    degen;
   } projection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [POS_W-1:0] req_sprite_pos_x = '0;
   logic [POS_W-1:0] req_sprite_pos_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [Q16_W-1:0] rsp_view_x, rsp_depth;
   logic signed [COL_W-1:0] rsp_screen_column, rsp_end_col;
   logic [HGT_W-1:0] rsp_sprite_height, rsp_start_col;
   logic [ROW_W-1:0] rsp_start_row, rsp_end_row;
   logic rsp_degenerate;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [POS_W-1:0] csr_data = '0;

   sprite_camera_projection_unit dut (.*);

   // Mirror of the camera registers
   logic [POS_W-1:0]        cam_pos_x = PLAYER_POS_X_RST;
   logic [POS_W-1:0]        cam_pos_y = PLAYER_POS_Y_RST;
   logic signed [VEC_W-1:0] cam_dir_x = VIEW_DIR_X_RST;
   logic signed [VEC_W-1:0] cam_dir_y = VIEW_DIR_Y_RST;
   logic signed [VEC_W-1:0] cam_pln_x = CAM_PLANE_X_RST;
   logic signed [VEC_W-1:0] cam_pln_y = CAM_PLANE_Y_RST;

   sprite_type     sprite_queue[$];
   projection_type projection_queue[$];
   int  error_count = 0;
   int  sprites_sent = 0;
   int  projections_seen = 0;
   int  degenerate_seen = 0;
   bit  quiet_tail = 1'b0;
   bit  req_fire = 1'b0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  backlog_left = 0;
   bit  backlog_done = 1'b0;
   int  idle_cycles = 0;

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Project one sprite through the mirrored camera
   function automatic projection_type project_sprite(sprite_type s);
      projection_type p;
      longint rel_x, rel_y, det, nx, ny, vx, dp, col, h, half, v;
      rel_x = longint'(s.x) - longint'(cam_pos_x);
      rel_y = longint'(s.y) - longint'(cam_pos_y);
      det = longint'(cam_pln_x) * longint'(cam_dir_y)
          - longint'(cam_dir_x) * longint'(cam_pln_y);
      p.degen = (det == 0);
      if (det == 0) begin
         vx = 0;
         dp = 65536;
         col = SCREEN_WIDTH_DEF / 2;
      end else begin
         nx = longint'(cam_dir_y) * rel_x - longint'(cam_dir_x) * rel_y;
         ny = longint'(cam_pln_x) * rel_y - longint'(cam_pln_y) * rel_x;
         vx = (nx * 16384) / det;
         dp = (ny * 16384) / det;
         if (vx > 64'sd2147483647) vx = 64'sd2147483647;
         if (vx < -64'sd2147483648) vx = -64'sd2147483648;
         if (dp > 64'sd2147483647) dp = 64'sd2147483647;
         if (dp < -64'sd2147483648) dp = -64'sd2147483648;
         if (dp == 0) dp = 65536;
         col = (longint'(SCREEN_WIDTH_DEF / 2) * (dp + vx)) / dp;
         if (col > 32767) col = 32767;
         if (col < -32768) col = -32768;
      end
      h = (longint'(SCREEN_HEIGHT_DEF) * 65536) / dp;
      if (h < 0) h = -h;
      if (h > 32767) h = 32767;
      half = h / 2;
      p.view_x = vx[31:0];
      p.depth  = dp[31:0];
      p.column = col[15:0];
      p.height = h[14:0];
      v = col - half;
      if (v < 0) v = 0;
      p.start_col = v[14:0];
      v = col + half;
      if (v >= SCREEN_WIDTH_DEF) v = SCREEN_WIDTH_DEF - 1;
      p.end_col = v[15:0];
      v = SCREEN_HEIGHT_DEF / 2 - half;
      if (v < 0) v = 0;
      p.start_row = v[11:0];
      v = SCREEN_HEIGHT_DEF / 2 + half;
      if (v >= SCREEN_HEIGHT_DEF) v = SCREEN_HEIGHT_DEF - 1;
      p.end_row = v[11:0];
      return p;
   endfunction

   // Drive sprites: hold until transfer, then idle in bursts or advance
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_fire)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (sprite_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            send_gap <= $urandom_range(0, 14);
         end else begin
            sprite_type s;
            s = sprite_queue.pop_front();
            req_valid <= 1'b1;
            req_sprite_pos_x <= s.x;
            req_sprite_pos_y <= s.y;
         end
      end
   end

   // Receiver stalls: random bursts plus one long hold-off to back up the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (backlog_left > 0) begin
         rsp_ready <= 1'b0;
         backlog_left <= backlog_left - 1;
      end else if (!backlog_done && sprites_sent >= 200) begin
         rsp_ready <= 1'b0;
         backlog_left <= BACKLOG_CYCLES;
         backlog_done <= 1'b1;
      end else if (recv_gap > 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= recv_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         recv_gap <= $urandom_range(0, 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Predict on input transfer, check on result transfer
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && req_valid && req_ready) begin
         projection_queue.push_back(project_sprite({req_sprite_pos_x, req_sprite_pos_y}));
         sprites_sent <= sprites_sent + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         projections_seen <= projections_seen + 1;
         if (projection_queue.size() == 0) begin
            $display("%0t: unexpected result, view_x %0d depth %0d", $time,
                     rsp_view_x, rsp_depth);
            error_count <= error_count + 1;
         end else begin
            projection_type e, a;
            e = projection_queue.pop_front();
            a = '{rsp_view_x, rsp_depth, rsp_screen_column, rsp_sprite_height,
                  rsp_start_col, rsp_end_col, rsp_start_row, rsp_end_row,
                  rsp_degenerate};
            if (e.degen) degenerate_seen <= degenerate_seen + 1;
            if (a !== e) begin
               $display("%0t: mismatch expected vx %0d dp %0d col %0d h %0d sc %0d ec %0d sr %0d er %0d dg %0b",
                        $time, e.view_x, e.depth, e.column, e.height, e.start_col,
                        e.end_col, e.start_row, e.end_row, e.degen);
               $display("%0t:          actual   vx %0d dp %0d col %0d h %0d sc %0d ec %0d sr %0d er %0d dg %0b",
                        $time, a.view_x, a.depth, a.column, a.height, a.start_col,
                        a.end_col, a.start_row, a.end_row, a.degen);
               error_count <= error_count + 1;
            end
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, projection_queue.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Write one camera register and update the mirror
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [POS_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PLAYER_POS_X: cam_pos_x = data;
         CSR_PLAYER_POS_Y: cam_pos_y = data;
         CSR_VIEW_DIR_X:   cam_dir_x = data[VEC_W-1:0];
         CSR_VIEW_DIR_Y:   cam_dir_y = data[VEC_W-1:0];
         CSR_CAM_PLANE_X:  cam_pln_x = data[VEC_W-1:0];
         CSR_CAM_PLANE_Y:  cam_pln_y = data[VEC_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_camera(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                              logic [VEC_W-1:0] dx, logic [VEC_W-1:0] dy,
                              logic [VEC_W-1:0] cx, logic [VEC_W-1:0] cy);
      // upper data bits are noise for the vector registers
      write_csr(CSR_PLAYER_POS_X, px);
      write_csr(CSR_PLAYER_POS_Y, py);
      write_csr(CSR_VIEW_DIR_X, {8'($urandom), dx});
      write_csr(CSR_VIEW_DIR_Y, {8'($urandom), dy});
      write_csr(CSR_CAM_PLANE_X, {8'($urandom), cx});
      write_csr(CSR_CAM_PLANE_Y, {8'($urandom), cy});
   endtask

   // Wait for every result, then let the pipeline settle
   task automatic drain();
      do @(posedge clock);
      while (sprite_queue.size() != 0 || req_valid || projection_queue.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sprites mostly near the player, some anywhere on the map
   task automatic push_random(int count);
      sprite_type s;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            s.x = POS_W'($urandom);
            s.y = POS_W'($urandom);
         end else begin
            s.x = cam_pos_x + POS_W'($signed($urandom_range(0, 2**20)) - 2**19);
            s.y = cam_pos_y + POS_W'($signed($urandom_range(0, 2**20)) - 2**19);
         end
         sprite_queue.push_back(s);
      end
   endtask

   // Random camera: a unit-ish direction and plane or fully random vectors
   task automatic random_camera();
      if ($urandom_range(0, 1))
         load_camera(POS_W'($urandom), POS_W'($urandom), VEC_W'($urandom),
                     VEC_W'($urandom), VEC_W'($urandom), VEC_W'($urandom));
      else
         load_camera(POS_W'($urandom_range(0, 2**24 - 1)),
                     POS_W'($urandom_range(0, 2**24 - 1)),
                     VEC_W'($signed($urandom_range(0, 32768)) - 16384),
                     VEC_W'($signed($urandom_range(0, 32768)) - 16384),
                     VEC_W'($signed($urandom_range(0, 21626)) - 10813),
                     VEC_W'($signed($urandom_range(0, 21626)) - 10813));
   endtask

   // Stimulus
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset camera: extremes, sprite on the player (zero depth), one step off
      sprite_queue.push_back('{24'h000000, 24'h000000});
      sprite_queue.push_back('{24'hFFFFFF, 24'hFFFFFF});
      sprite_queue.push_back('{24'hFFFFFF, 24'h000000});
      sprite_queue.push_back('{24'h000000, 24'hFFFFFF});
      sprite_queue.push_back('{24'h000001, 24'h000000});
      sprite_queue.push_back('{24'h010000, 24'h000001});
      sprite_queue.push_back('{24'h555555, 24'hAAAAAA});
      sprite_queue.push_back('{24'hAAAAAA, 24'h555555});
      drain();

      // Extreme camera vectors and player at the far corner
      load_camera(24'hFFFFFF, 24'hFFFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      sprite_queue.push_back('{24'h000000, 24'h000000});
      sprite_queue.push_back('{24'hFFFFFF, 24'hFFFFFF});
      sprite_queue.push_back('{24'hFFFFFF, 24'h000000});
      sprite_queue.push_back('{24'h000000, 24'hFFFFFF});
      drain();

      // Zero determinant, and writes to spare indexes that must be dropped
      load_camera(24'h080000, 24'h080000, 16'h0000, 16'h0000, 16'h4000, 16'h2A3D);
      write_csr(CSR_SPARE_6, 24'hFFFFFF);
      write_csr(CSR_SPARE_7, 24'h123456);
      sprite_queue.push_back('{24'h000000, 24'hFFFFFF});
      sprite_queue.push_back('{24'h080000, 24'h080000});
      sprite_queue.push_back('{24'hFFFFFF, 24'h000000});
      drain();
      load_camera(24'h000000, 24'h000000, 16'h4000, 16'h4000, 16'h2000, 16'h2000);
      sprite_queue.push_back('{24'h123456, 24'h654321});
      sprite_queue.push_back('{24'hFFFFFF, 24'hFFFFFF});
      drain();

      // Random phases; the long receiver hold-off falls in the second
      for (int ph = 0; ph < 8; ph++) begin
         random_camera();
         if (ph == 7) quiet_tail = 1'b1;
         push_random(140);
         drain();
      end

      $display("Projected %0d sprites across 12 camera settings, %0d degenerate.",
               projections_seen, degenerate_seen);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
